### hw/rtl/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 8;
	// Dividend width: operand magnitude shifted up by the fraction bits.
	localparam int DIV_W     = DATA_W + FRAC_BITS;

	typedef enum logic [3:0] {
		MODE_ADD      = 4'd0,
		MODE_SUB      = 4'd1,
		MODE_MUL      = 4'd2,
		MODE_DIV      = 4'd3,
		MODE_EQ       = 4'd4,
		MODE_NE       = 4'd5,
		MODE_LE       = 4'd6,
		MODE_GE       = 4'd7,
		MODE_LT       = 4'd8,
		MODE_GT       = 4'd9,
		MODE_MIN      = 4'd10,
		MODE_MAX      = 4'd11,
		MODE_INC      = 4'd12,
		MODE_DEC      = 4'd13,
		MODE_FROM_INT = 4'd14,
		MODE_TO_INT   = 4'd15
	} mode_t;

	// Result side band that rides along the divider stages.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              compare_true;
		logic              divide_by_zero;
		logic              use_quot;
		logic              quot_neg;
	} side_t;

	// Finished result item.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              compare_true;
		logic              divide_by_zero;
	} res_t;

endpackage

### hw/rtl/fpa_front.sv
// Front end: input register, simple ops, multiplier and divider operand prep.
module fpa_front import fpa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic [3:0]               mode,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     v_o,
	output side_t                    side_o,
	output logic [DATA_W-1:0]        num_o,
	output logic [DATA_W-1:0]        den_o
);

	logic                       v_s1, v_s2, v_s3;
	mode_t                      mode_s1;
	logic signed [DATA_W-1:0]   a_s1, b_s1;
	side_t                      side_s2, side_s3;
	logic                       is_mul_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0]          mag_a_s2, mag_b_s2, mag_a_s3, mag_b_s3;

	side_t                      side_c;
	side_t                      side_m;
	logic                       lt_c, eq_c;

	// Stage 1: capture the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode_t'(mode);
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
	end

	// Stage 2: simple ops, comparisons, divider setup.
	always_comb begin
		lt_c   = a_s1 < b_s1;
		eq_c   = a_s1 == b_s1;
		side_c = '0;
		case (mode_s1)
			MODE_ADD:      side_c.value = a_s1 + b_s1;
			MODE_SUB:      side_c.value = a_s1 - b_s1;
			MODE_MUL:      side_c.value = '0;
			MODE_DIV: begin
				side_c.divide_by_zero = (b_s1 == '0);
				side_c.use_quot       = (b_s1 != '0);
				side_c.quot_neg       = a_s1[DATA_W-1] ^ b_s1[DATA_W-1];
			end
			MODE_EQ:       side_c.compare_true = eq_c;
			MODE_NE:       side_c.compare_true = !eq_c;
			MODE_LE:       side_c.compare_true = lt_c || eq_c;
			MODE_GE:       side_c.compare_true = !lt_c;
			MODE_LT:       side_c.compare_true = lt_c;
			MODE_GT:       side_c.compare_true = !lt_c && !eq_c;
			MODE_MIN:      side_c.value = (!lt_c && !eq_c) ? b_s1 : a_s1;
			MODE_MAX:      side_c.value = (!lt_c && !eq_c) ? a_s1 : b_s1;
			MODE_INC:      side_c.value = a_s1 + DATA_W'(1);
			MODE_DEC:      side_c.value = a_s1 - DATA_W'(1);
			MODE_FROM_INT: side_c.value = a_s1 << FRAC_BITS;
			MODE_TO_INT:   side_c.value = a_s1 >>> FRAC_BITS;
			default:       side_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2   <= side_c;
			is_mul_s2 <= (mode_s1 == MODE_MUL);
			prod_s2   <= a_s1 * b_s1;
			mag_a_s2  <= a_s1[DATA_W-1] ? DATA_W'(-a_s1) : DATA_W'(a_s1);
			mag_b_s2  <= b_s1[DATA_W-1] ? DATA_W'(-b_s1) : DATA_W'(b_s1);
		end
	end

	// Stage 3: fold in the scaled product.
	always_comb begin
		side_m = side_s2;
		if (is_mul_s2)
			side_m.value = prod_s2[FRAC_BITS +: DATA_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3  <= side_m;
			mag_a_s3 <= mag_a_s2;
			mag_b_s3 <= mag_b_s2;
		end
	end

	assign v_o    = v_s3;
	assign side_o = side_s3;
	assign num_o  = mag_a_s3;
	assign den_o  = mag_b_s3;

	a_dz_clean: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && side_s3.divide_by_zero |->
			side_s3.value == '0 && !side_s3.compare_true && !side_s3.use_quot)
		else $error("divide by zero item carries a stray result");

endmodule

### hw/rtl/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side band.
module fpa_div import fpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              v_i,
	input  side_t             side_i,
	input  logic [DATA_W-1:0] num_i,
	input  logic [DATA_W-1:0] den_i,
	output logic              v_o,
	output side_t             side_o,
	output logic [DATA_W-1:0] quot_o
);

	logic              v_s    [DIV_W];
	side_t             side_s [DIV_W];
	logic [DATA_W-1:0] rem_s  [DIV_W];
	logic [DATA_W-1:0] den_s  [DIV_W];
	// Dividend bits shift out the top while quotient bits shift in below.
	logic [DIV_W-1:0]  sh_s   [DIV_W];

	for (genvar k = 0; k < DIV_W; k++) begin : g_stage
		logic              v_p;
		side_t             side_p;
		logic [DATA_W-1:0] rem_p, den_p;
		logic [DIV_W-1:0]  sh_p;
		logic [DATA_W:0]   trial;
		logic              fit;

		if (k == 0) begin : g_first
			assign v_p    = v_i;
			assign side_p = side_i;
			assign rem_p  = '0;
			assign den_p  = den_i;
			assign sh_p   = {num_i, FRAC_BITS'(0)};
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign side_p = side_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign den_p  = den_s[k-1];
			assign sh_p   = sh_s[k-1];
		end

		assign trial = {rem_p, sh_p[DIV_W-1]} - {1'b0, den_p};
		assign fit   = !trial[DATA_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (adv)
				v_s[k] <= v_p;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_p;
				den_s[k]  <= den_p;
				rem_s[k]  <= fit ? trial[DATA_W-1:0] : {rem_p[DATA_W-2:0], sh_p[DIV_W-1]};
				sh_s[k]   <= {sh_p[DIV_W-2:0], fit};
			end
		end
	end

	assign v_o    = v_s[DIV_W-1];
	assign side_o = side_s[DIV_W-1];
	assign quot_o = sh_s[DIV_W-1][DATA_W-1:0];

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[DIV_W-1] && den_s[DIV_W-1] != '0 |-> rem_s[DIV_W-1] < den_s[DIV_W-1])
		else $error("divider remainder not below divisor");

endmodule

### hw/rtl/fpa_out.sv
// Result finish (quotient sign), output register and skid stage.
module fpa_out import fpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_i,
	input  side_t             side_i,
	input  logic [DATA_W-1:0] quot_i,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_stall,
	output res_t              res_o
);

	logic out_v_q, sk_v_q;
	res_t out_q, sk_q, res_c;
	logic out_take, load_out, load_sk;

	always_comb begin
		res_c.compare_true   = side_i.compare_true;
		res_c.divide_by_zero = side_i.divide_by_zero;
		if (side_i.use_quot)
			res_c.value = side_i.quot_neg ? DATA_W'(-quot_i) : quot_i;
		else
			res_c.value = side_i.value;
	end

	// Pipeline moves only while the skid slot is free.
	assign adv      = !sk_v_q;
	assign out_take = out_v_q && !out_stall;
	assign load_out = (sk_v_q && out_take) || (!sk_v_q && v_i && (!out_v_q || !out_stall));
	assign load_sk  = !sk_v_q && v_i && out_v_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else begin
			if (load_out)
				out_v_q <= 1'b1;
			else if (out_take)
				out_v_q <= 1'b0;
			if (load_sk)
				sk_v_q <= 1'b1;
			else if (out_take)
				sk_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= sk_v_q ? sk_q : res_c;
		if (load_sk)
			sk_q <= res_c;
	end

	assign out_valid = out_v_q;
	assign res_o     = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid holds a result while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && out_stall && v_i))
		else $error("skid filled without a stalled output");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q && out_stall |=> sk_v_q && $stable(sk_q))
		else $error("skid lost its result under stall");

endmodule

### hw/rtl/fixed_point_alu.sv
// Top level of the signed 32-bit fixed-point ALU (Q24.8 by default).
//
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  mode, operand_a, operand_b
// out      source     out_valid/out_stall  result_value, compare_true, divide_by_zero
//
// One item per cycle while in_stall is low; every op returns exactly one result, in order.
// Every op passes the front end stages, the restoring divider that resolves one
// quotient bit per stage, and the output register, so all ops share one latency.
// arst_n clears only valid bits; no clearing pass, ready right after reset.
// A stalled result parks in the output register, the next one in a skid slot;
// in_stall is that slot's full flag, so the pipeline freezes without loss.
module fixed_point_alu import fpa_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [3:0]               mode,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] result_value,
	output logic                     compare_true,
	output logic                     divide_by_zero
);

	// Global advance: the whole pipeline moves together.
	logic              adv;
	logic              fr_v, dv_v;
	side_t             fr_side, dv_side;
	logic [DATA_W-1:0] fr_num, fr_den, dv_quot;
	res_t              res;

	// Decode, add/compare/select ops, multiply, operand magnitudes.
	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.mode      (mode),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.v_o       (fr_v),
		.side_o    (fr_side),
		.num_o     (fr_num),
		.den_o     (fr_den)
	);

	// Division array; other results ride along in the side band to keep order.
	fpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_i    (fr_v),
		.side_i (fr_side),
		.num_i  (fr_num),
		.den_i  (fr_den),
		.v_o    (dv_v),
		.side_o (dv_side),
		.quot_o (dv_quot)
	);

	// Quotient sign fix, result register and skid.
	fpa_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_i       (dv_v),
		.side_i    (dv_side),
		.quot_i    (dv_quot),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_o     (res)
	);

	assign in_stall       = !adv;
	assign result_value   = res.value;
	assign compare_true   = res.compare_true;
	assign divide_by_zero = res.divide_by_zero;

endmodule

### dv/tb.sv
// Testbench for fixed_point_alu: directed table plus random traffic, checked against typed answers and a predictor.
module tb;
	import fpa_pkg::*;

	// Raw encoding of 1.0 in the fixed-point format.
	localparam logic [DATA_W-1:0] ONE = 32'(1) << FRAC_BITS;
	// Pipeline depth (front, divider and output stages) plus margin for stray results.
	localparam int DRAIN_CYCLES = 3 + DIV_W + 1 + 16;
	// Long receiver hold-off; well past the pipeline depth so in_stall rises.
	localparam int HOLD_CYCLES  = 160;
	// Cycles with no transfer on either channel before the run is called hung.
	localparam int QUIET_LIMIT  = 1500;
	localparam int RAND_ITEMS   = 1700;
	localparam int DIR_ROWS     = 25;

	// Directed stimulus row; want is used only when known is set.
	typedef struct packed {
		mode_t             op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic              known;
		res_t              want;
	} dir_row_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     in_stall;
	logic [3:0]               mode           = MODE_ADD;
	logic signed [DATA_W-1:0] operand_a      = '0;
	logic signed [DATA_W-1:0] operand_b      = '0;
	logic                     out_valid;
	logic                     out_stall      = 1'b0;
	logic signed [DATA_W-1:0] result_value;
	logic                     compare_true;
	logic                     divide_by_zero;

	// Expected results, oldest first, one per accepted input transfer.
	res_t result_q[$];
	res_t oldest_want;
	int   err_cnt      = 0;
	int   quiet_cycles = 0;

	// Idle controls for sender (tx) and receiver (rx); cleared for the calm stretch.
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	// Each bump of hold_asks asks the receiver for one long hold-off.
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// Extremes, every operation, and the corner cases: zero divisor, division
	// overflow, equal operands for min, to_int rounding toward minus
	// infinity, from_int overflow, wrap of inc/dec/add/sub.
	dir_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{MODE_ADD,      32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
		'{MODE_ADD,      32'h7fff_ffff, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
		'{MODE_SUB,      32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
		'{MODE_MUL,      ONE,           ONE * 3,       1'b1, '{ONE * 3,       1'b0, 1'b0}},
		'{MODE_MUL,      32'h8000_0000, 32'h8000_0000, 1'b0, '0},
		'{MODE_MUL,      -(ONE * 3 / 2), ONE,          1'b0, '0},
		'{MODE_DIV,      ONE,           32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
		'{MODE_DIV,      32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
		'{MODE_DIV,      ONE * 3,       ONE * 2,       1'b1, '{ONE * 3 / 2,   1'b0, 1'b0}},
		'{MODE_DIV,      32'h8000_0000, 32'hffff_ffff, 1'b0, '0},
		'{MODE_DIV,      -ONE,          ONE * 3,       1'b0, '0},
		'{MODE_EQ,       32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
		'{MODE_NE,       32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
		'{MODE_LE,       32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
		'{MODE_GE,       32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
		'{MODE_LT,       32'h7fff_ffff, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
		'{MODE_GT,       32'h7fff_ffff, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
		'{MODE_MIN,      32'h0000_1234, 32'h0000_1234, 1'b1, '{32'h0000_1234, 1'b0, 1'b0}},
		'{MODE_MAX,      32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
		'{MODE_MIN,      32'hffff_ffff, 32'h0000_0001, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
		'{MODE_INC,      32'h7fff_ffff, 32'hffff_ffff, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
		'{MODE_DEC,      32'h8000_0000, 32'h0000_0000, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
		'{MODE_FROM_INT, 32'h0000_0005, 32'h5555_5555, 1'b1, '{ONE * 5,       1'b0, 1'b0}},
		'{MODE_FROM_INT, 32'h8000_0001, 32'h0000_0000, 1'b0, '0},
		'{MODE_TO_INT,   32'hffff_ffff, 32'haaaa_aaaa, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}}
	};

	fixed_point_alu dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_value   (result_value),
		.compare_true   (compare_true),
		.divide_by_zero (divide_by_zero)
	);

	always #5 clk = ~clk;

	// Expected result of one operation on raw Q-format operands.
	function automatic res_t alu_predict(input mode_t op, input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		res_t            r;
		longint          sa;
		longint          sb;
		longint          prod;
		longint unsigned mag_a;
		longint unsigned mag_b;
		longint unsigned quot;
		r  = '0;
		sa = a;
		sb = b;
		case (op)
			MODE_ADD:      r.value = a + b;
			MODE_SUB:      r.value = a - b;
			MODE_MUL: begin
				// full 64-bit product, arithmetic shift, keep the low word
				prod    = sa * sb;
				prod    = prod >>> FRAC_BITS;
				r.value = prod[DATA_W-1:0];
			end
			MODE_DIV: begin
				if (b == '0) begin
					r.divide_by_zero = 1'b1;
				end else begin
					// magnitude divide truncates toward zero; sign applied after
					mag_a = (sa < 0) ? -sa : sa;
					mag_b = (sb < 0) ? -sb : sb;
					quot  = (mag_a << FRAC_BITS) / mag_b;
					if ((sa < 0) != (sb < 0))
						quot = -quot;
					r.value = quot[DATA_W-1:0];
				end
			end
			MODE_EQ:       r.compare_true = (a == b);
			MODE_NE:       r.compare_true = (a != b);
			MODE_LE:       r.compare_true = (a <= b);
			MODE_GE:       r.compare_true = (a >= b);
			MODE_LT:       r.compare_true = (a < b);
			MODE_GT:       r.compare_true = (a > b);
			MODE_MIN:      r.value = (a > b) ? b : a;
			MODE_MAX:      r.value = (a > b) ? a : b;
			MODE_INC:      r.value = a + 1;
			MODE_DEC:      r.value = a - 1;
			MODE_FROM_INT: r.value = a << FRAC_BITS;
			default:       r.value = a >>> FRAC_BITS;
		endcase
		return r;
	endfunction

	// Operand mix: full-range noise, small values near zero, the extremes,
	// whole numbers, and random magnitudes.
	function automatic logic [DATA_W-1:0] rand_operand();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return 32'($urandom_range(4095)) - 32'd2048;
			6: begin
				case ($urandom_range(4))
					0:       return 32'h8000_0000;
					1:       return 32'h7fff_ffff;
					2:       return 32'h0000_0000;
					3:       return 32'hffff_ffff;
					default: return 32'h0000_0001;
				endcase
			end
			7:          return (32'($urandom_range(255)) - 32'd128) << FRAC_BITS;
			default:    return $urandom >> $urandom_range(31);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Offer one item, hold it until the transfer, then log its expected result.
	// Random gaps fall only between items so a stalled payload stays put.
	task automatic send_item(input mode_t op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input res_t want);
		while (tx_idle_en && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= op;
		operand_a <= a;
		operand_b <= b;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		result_q.push_back(want);
	endtask

	// Sender stops offering and waits out every pending result.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, a calm stretch, and one long hold-off counted
	// here so the pipeline fills and backs up into in_stall.
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= rx_idle_en && ($urandom_range(99) < 23);
		end
	end

	// Result checker: each output transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%h cmp=%b dz=%b",
					result_value, compare_true, divide_by_zero));
			end else begin
				oldest_want = result_q.pop_front();
				if (result_value !== oldest_want.value)
					report_mismatch($sformatf("result_value got %h want %h",
						result_value, oldest_want.value));
				if (compare_true !== oldest_want.compare_true)
					report_mismatch($sformatf("compare_true got %b want %b",
						compare_true, oldest_want.compare_true));
				if (divide_by_zero !== oldest_want.divide_by_zero)
					report_mismatch($sformatf("divide_by_zero got %b want %b",
						divide_by_zero, oldest_want.divide_by_zero));
			end
		end
	end

	// Watchdog: too long with no transfer on either channel means a hang.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		mode_t             op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; rows without a typed answer go through the predictor
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
				dir_rows[i].known ? dir_rows[i].want
					: alu_predict(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b));
		drain_results();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// long hold-off while the sender keeps offering
			if (n == 300)
				hold_asks++;
			// calm stretch: back-to-back transfers on both sides
			if (n == 600) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			if (n == 950) begin
				tx_idle_en = 1'b1;
				rx_idle_en = 1'b1;
			end
			// sender pause until the pipeline is empty
			if (n == 1250)
				drain_results();
			op = mode_t'($urandom_range(15));
			a  = rand_operand();
			b  = rand_operand();
			// equal operands for compares and min/max; zero divisors for div
			if ($urandom_range(99) < 15)
				b = a;
			else if (op == MODE_DIV && $urandom_range(99) < 10)
				b = '0;
			send_item(op, a, b, alu_predict(op, a, b));
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_div.sv
hw/rtl/fpa_out.sv
hw/rtl/fixed_point_alu.sv
dv/tb.sv
